/* src/akf_pkg.sv */
`default_nettype none

package akf_pkg;

  // Datapath word: signed fixed point with a configurable number of fraction bits.
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Field and register widths.
  localparam int unsigned MEAS_W = 25;
  localparam int unsigned DT_W   = 16;
  localparam int unsigned CFG_W  = 16;

  // Register port: 32-bit data, registers at byte addresses 0 and 4.
  localparam int unsigned APB_DW = 32;
  localparam int unsigned ADDR_W = 3;

  // Register select, taken from paddr[ADDR_W-1].
  localparam logic REG_PROCESS_NOISE = 1'b0;
  localparam logic REG_MEASURE_NOISE = 1'b1;

  // Reset values of the noise registers.
  localparam logic [CFG_W-1:0] PROCESS_NOISE_RST = 16'd66;
  localparam logic [CFG_W-1:0] MEASURE_NOISE_RST = 16'd1966;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh8000_0000;

  // Sums of up to four words fit in three extra bits.
  localparam int unsigned SUM_W = DATA_W + 3;

  // Clamp a wide sum back into one data word.
  function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] x);
    logic same;
    same = (&x[SUM_W-1:DATA_W-1]) | ~(|x[SUM_W-1:DATA_W-1]);
    if (same) begin
      return x[DATA_W-1:0];
    end else if (x[SUM_W-1]) begin
      return DATA_MIN;
    end else begin
      return DATA_MAX;
    end
  endfunction

  // Sign-extend a data word to the sum width.
  function automatic logic signed [SUM_W-1:0] sx(input logic signed [DATA_W-1:0] x);
    return SUM_W'(x);
  endfunction

endpackage

`default_nettype wire

/* src/akf_div.sv */
`default_nettype none

module akf_div #(
  parameter int unsigned FRAC_BITS = akf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [akf_pkg::DATA_W-1:0]   dividend_i,
  input  logic signed [akf_pkg::DATA_W-1:0]   divisor_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic signed [akf_pkg::DATA_W-1:0]   quotient_o
);
  import akf_pkg::*;

  // Restoring division of |a| * 2^FRAC_BITS by |b|, two quotient bits per cycle.
  localparam int unsigned NUM_W = DATA_W + FRAC_BITS;
  localparam int unsigned QW    = NUM_W + (NUM_W % 2);
  localparam int unsigned NIT   = QW / 2;
  localparam int unsigned CNT_W = $clog2(NIT);

  logic              run_q, fin_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [QW-1:0]     num_q;
  logic [DATA_W-1:0] den_q;
  logic [DATA_W-1:0] rem_q;
  logic              neg_q, dz_q, a_neg_q, a_zero_q;

  logic [DATA_W-1:0] abs_a, abs_b;
  logic [DATA_W:0]   r1, r2;
  logic [DATA_W-1:0] r1m, r2m;
  logic              q1, q2;
  logic              over;

  assign abs_a = dividend_i[DATA_W-1] ? DATA_W'(-dividend_i) : DATA_W'(dividend_i);
  assign abs_b = divisor_i[DATA_W-1]  ? DATA_W'(-divisor_i)  : DATA_W'(divisor_i);

  always_comb begin
    r1  = {rem_q, num_q[QW-1]};
    q1  = (r1 >= {1'b0, den_q});
    r1m = q1 ? DATA_W'(r1 - {1'b0, den_q}) : r1[DATA_W-1:0];
    r2  = {r1m, num_q[QW-2]};
    q2  = (r2 >= {1'b0, den_q});
    r2m = q2 ? DATA_W'(r2 - {1'b0, den_q}) : r2[DATA_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      fin_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i && !run_q && !fin_q) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == CNT_W'(NIT - 1)) begin
        run_q <= 1'b0;
        fin_q <= 1'b1;
      end
    end else begin
      fin_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !run_q && !fin_q) begin
      num_q    <= QW'({abs_a, {FRAC_BITS{1'b0}}});
      den_q    <= abs_b;
      rem_q    <= '0;
      neg_q    <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      dz_q     <= (divisor_i == '0);
      a_neg_q  <= dividend_i[DATA_W-1];
      a_zero_q <= (dividend_i == '0);
    end else if (run_q) begin
      num_q <= {num_q[QW-3:0], q1, q2};
      rem_q <= r2m;
    end
  end

  // Sign, saturation and the zero-divisor rule are applied on the way out.
  always_comb begin
    over = |num_q[QW-1:DATA_W];
    if (dz_q) begin
      if (a_zero_q) begin
        quotient_o = '0;
      end else if (a_neg_q) begin
        quotient_o = DATA_MIN;
      end else begin
        quotient_o = DATA_MAX;
      end
    end else if (!neg_q) begin
      quotient_o = (over || num_q[DATA_W-1]) ? DATA_MAX : $signed(num_q[DATA_W-1:0]);
    end else if (over || (num_q[DATA_W-1] && |num_q[DATA_W-2:0])) begin
      quotient_o = DATA_MIN;
    end else begin
      quotient_o = $signed(-num_q[DATA_W-1:0]);
    end
  end

  assign busy_o = run_q | fin_q;
  assign done_o = fin_q;

endmodule

`default_nettype wire

/* src/angle_kalman_filter_step_unit.sv */
// Angle Kalman filter step with a zero-rate predict and a measurement update.
//
// Input channel (in_valid_i / in_ready_o) carries one word per measurement:
// the measured angle and the time since the previous word, both fixed point
// with FRAC_BITS fraction bits. Each accepted word yields exactly one output
// word (out_valid_o / out_ready_i) holding the updated filtered angle.
//
// One multiplier and a two-bit-per-cycle serial divider are shared under a
// small sequencer. The two gain divisions dominate. The output word becomes
// valid in the same cycle in which in_ready_o rises again. in_ready_o is low
// while a word is worked on.
//
// The result sits in an output register, so the next word can be accepted
// while it waits. If the receiver stalls long enough that a new result is due
// while the old one is still held, the sequencer waits in its last step.
//
// Reset clears the angle and covariance, restores the noise register defaults.
// Write registers over the APB-style port only while idle; the block won't check.

`default_nettype none

module angle_kalman_filter_step_unit #(
  parameter int unsigned FRAC_BITS = akf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [akf_pkg::ADDR_W-1:0]          paddr,
  input  logic [akf_pkg::APB_DW-1:0]          pwdata,
  output logic [akf_pkg::APB_DW-1:0]          prdata,
  output logic                                pready,
  // Measurement channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [akf_pkg::MEAS_W-1:0]   measured_angle_i,
  input  logic [akf_pkg::DT_W-1:0]            delta_time_i,
  // Result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [akf_pkg::DATA_W-1:0]   filtered_angle_o
);
  import akf_pkg::*;

  localparam int unsigned PROD_W = 2 * DATA_W;
  localparam logic signed [PROD_W-1:0] RND = PROD_W'(1) <<< (FRAC_BITS - 1);

  // Sequencer steps. Each multiply takes an issue step and an accumulate step.
  localparam int unsigned ST_W = 5;
  localparam logic [ST_W-1:0] ST_IDLE    = 5'd0;
  localparam logic [ST_W-1:0] ST_MUL_D11 = 5'd1;
  localparam logic [ST_W-1:0] ST_ACC_D11 = 5'd2;
  localparam logic [ST_W-1:0] ST_UPD_E   = 5'd3;
  localparam logic [ST_W-1:0] ST_MUL_E   = 5'd4;
  localparam logic [ST_W-1:0] ST_ACC_E   = 5'd5;
  localparam logic [ST_W-1:0] ST_CALC_S  = 5'd6;
  localparam logic [ST_W-1:0] ST_DIV_K0  = 5'd7;
  localparam logic [ST_W-1:0] ST_WAIT_K0 = 5'd8;
  localparam logic [ST_W-1:0] ST_DIV_K1  = 5'd9;
  localparam logic [ST_W-1:0] ST_WAIT_K1 = 5'd10;
  localparam logic [ST_W-1:0] ST_MUL_Y   = 5'd11;
  localparam logic [ST_W-1:0] ST_ACC_ANG = 5'd12;
  localparam logic [ST_W-1:0] ST_MUL_C11 = 5'd13;
  localparam logic [ST_W-1:0] ST_ACC_C11 = 5'd14;
  localparam logic [ST_W-1:0] ST_MUL_C10 = 5'd15;
  localparam logic [ST_W-1:0] ST_ACC_C10 = 5'd16;
  localparam logic [ST_W-1:0] ST_MUL_C01 = 5'd17;
  localparam logic [ST_W-1:0] ST_ACC_C01 = 5'd18;
  localparam logic [ST_W-1:0] ST_MUL_C00 = 5'd19;
  localparam logic [ST_W-1:0] ST_ACC_C00 = 5'd20;
  localparam logic [ST_W-1:0] ST_DONE    = 5'd21;

  logic [ST_W-1:0] state_q, state_d;

  // Configuration registers.
  logic [CFG_W-1:0] pna_q, mn_q;
  logic             cfg_wr;

  // Filter state.
  logic signed [DATA_W-1:0] ang_q, c00_q, c01_q, c10_q, c11_q;

  // Per-word working registers.
  logic signed [MEAS_W-1:0] meas_q;
  logic [DT_W-1:0]          dt_q;
  logic signed [DATA_W-1:0] d11_q, e_q, s_q, y_q, k0_q, k1_q;
  logic signed [PROD_W-1:0] prod_q;

  // Output register.
  logic                     out_valid_q;
  logic signed [DATA_W-1:0] out_q;
  logic                     out_load;

  // Shared multiplier and its rounded, clamped result.
  logic signed [DATA_W-1:0] mul_a, mul_b, mul_res;
  logic signed [PROD_W-1:0] prod_shr;
  logic signed [DATA_W-1:0] dt_ext;

  // Divider handshake.
  logic                     div_start, div_busy, div_done;
  logic signed [DATA_W-1:0] div_num, div_q;

  logic in_fire;

  // ---------------------------------------------------------------------------
  // Register port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pna_q <= PROCESS_NOISE_RST;
      mn_q  <= MEASURE_NOISE_RST;
    end else if (cfg_wr) begin
      if (paddr[ADDR_W-1] == REG_PROCESS_NOISE) begin
        pna_q <= pwdata[CFG_W-1:0];
      end else begin
        mn_q <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[ADDR_W-1] == REG_PROCESS_NOISE) begin
      prdata = {{(APB_DW-CFG_W){1'b0}}, pna_q};
    end else begin
      prdata = {{(APB_DW-CFG_W){1'b0}}, mn_q};
    end
  end

  // ---------------------------------------------------------------------------
  // Handshakes
  // ---------------------------------------------------------------------------
  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign out_load   = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  assign out_valid_o      = out_valid_q;
  assign filtered_angle_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= ang_q;
    end
    if (in_fire) begin
      meas_q <= measured_angle_i;
      dt_q   <= delta_time_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared multiplier: operands picked by step, rounding constant folded in.
  // ---------------------------------------------------------------------------
  assign dt_ext = $signed({{(DATA_W-DT_W){1'b0}}, dt_q});

  always_comb begin
    case (state_q)
      ST_MUL_D11: begin
        mul_a = dt_ext;
        mul_b = c11_q;
      end
      ST_MUL_E: begin
        mul_a = dt_ext;
        mul_b = e_q;
      end
      ST_MUL_Y: begin
        mul_a = k0_q;
        mul_b = y_q;
      end
      ST_MUL_C11: begin
        mul_a = k1_q;
        mul_b = c01_q;
      end
      ST_MUL_C10: begin
        mul_a = k1_q;
        mul_b = c00_q;
      end
      ST_MUL_C01: begin
        mul_a = k0_q;
        mul_b = c01_q;
      end
      ST_MUL_C00: begin
        mul_a = k0_q;
        mul_b = c00_q;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b + RND;
  end

  // Floor shift gives round-half-up; the result is clamped to one word.
  always_comb begin
    prod_shr = prod_q >>> FRAC_BITS;
    if ((&prod_shr[PROD_W-1:DATA_W-1]) | ~(|prod_shr[PROD_W-1:DATA_W-1])) begin
      mul_res = prod_shr[DATA_W-1:0];
    end else if (prod_shr[PROD_W-1]) begin
      mul_res = DATA_MIN;
    end else begin
      mul_res = DATA_MAX;
    end
  end

  // ---------------------------------------------------------------------------
  // Shared divider for the two gains; both use the innovation variance.
  // ---------------------------------------------------------------------------
  assign div_start = (state_q == ST_DIV_K0) || (state_q == ST_DIV_K1);
  assign div_num   = (state_q == ST_DIV_K0) ? c00_q : c10_q;

  akf_div #(
    .FRAC_BITS (FRAC_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (s_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (div_q)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:    if (in_fire) state_d = ST_MUL_D11;
      ST_MUL_D11: state_d = ST_ACC_D11;
      ST_ACC_D11: state_d = ST_UPD_E;
      ST_UPD_E:   state_d = ST_MUL_E;
      ST_MUL_E:   state_d = ST_ACC_E;
      ST_ACC_E:   state_d = ST_CALC_S;
      ST_CALC_S:  state_d = ST_DIV_K0;
      ST_DIV_K0:  state_d = ST_WAIT_K0;
      ST_WAIT_K0: if (div_done) state_d = ST_DIV_K1;
      ST_DIV_K1:  state_d = ST_WAIT_K1;
      ST_WAIT_K1: if (div_done) state_d = ST_MUL_Y;
      ST_MUL_Y:   state_d = ST_ACC_ANG;
      ST_ACC_ANG: state_d = ST_MUL_C11;
      ST_MUL_C11: state_d = ST_ACC_C11;
      ST_ACC_C11: state_d = ST_MUL_C10;
      ST_MUL_C10: state_d = ST_ACC_C10;
      ST_ACC_C10: state_d = ST_MUL_C01;
      ST_MUL_C01: state_d = ST_ACC_C01;
      ST_ACC_C01: state_d = ST_MUL_C00;
      ST_MUL_C00: state_d = ST_ACC_C00;
      ST_ACC_C00: state_d = ST_DONE;
      ST_DONE:    if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Filter state. The covariance update runs in an order where each entry is
  // rewritten only after every product that reads its predicted value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_q <= '0;
      c00_q <= '0;
      c01_q <= '0;
      c10_q <= '0;
      c11_q <= '0;
    end else begin
      case (state_q)
        ST_UPD_E: begin
          c01_q <= sat_sum(sx(c01_q) - sx(d11_q));
          c10_q <= sat_sum(sx(c10_q) - sx(d11_q));
        end
        ST_ACC_E:   c00_q <= sat_sum(sx(c00_q) + sx(mul_res));
        ST_ACC_ANG: ang_q <= sat_sum(sx(ang_q) + sx(mul_res));
        ST_ACC_C11: c11_q <= sat_sum(sx(c11_q) - sx(mul_res));
        ST_ACC_C10: c10_q <= sat_sum(sx(c10_q) - sx(mul_res));
        ST_ACC_C01: c01_q <= sat_sum(sx(c01_q) - sx(mul_res));
        ST_ACC_C00: c00_q <= sat_sum(sx(c00_q) - sx(mul_res));
        default: begin
        end
      endcase
    end
  end

  // Working values of the current word.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_ACC_D11: d11_q <= mul_res;
      ST_UPD_E: begin
        e_q <= sat_sum(sx(d11_q) - sx(c01_q) - sx(c10_q)
                       + $signed({{(SUM_W-CFG_W){1'b0}}, pna_q}));
        y_q <= sat_sum(SUM_W'(meas_q) - sx(ang_q));
      end
      ST_CALC_S:  s_q <= sat_sum(sx(c00_q) + $signed({{(SUM_W-CFG_W){1'b0}}, mn_q}));
      ST_WAIT_K0: if (div_done) k0_q <= div_q;
      ST_WAIT_K1: if (div_done) k1_q <= div_q;
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_div_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_WAIT_K0 || state_q == ST_WAIT_K1))
    else $error("divider finished outside a gain wait step");

  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_busy)
    else $error("divider started while busy");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (state_q == ST_MUL_D11))
    else $error("accepted word did not start the sequence");

  a_out_holds_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && out_q == ang_q))
    else $error("output word does not match the filtered angle");

endmodule

`default_nettype wire
